>>> hdl/mtrg_pkg.sv
// ----------------------------------------------------------------------------
// MT19937 generator package
// Constants, the fill status type and the twist and tempering functions
// shared by the generator modules.
// ----------------------------------------------------------------------------
package mtrg_pkg;

  // Table geometry of the standard 32-bit generator.
  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned SHIFT_OFFSET = 397;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned COUNT_W      = $clog2(STATE_WORDS);

  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] FILL_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] SEED_DEFAULT = 32'h4141_f00d;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [COUNT_W-1:0] count_t;

  // Status of the table fill, handed from the seeder to the chain control.
  typedef struct packed {
    logic  busy;
    word_t word;
  } fill_t;

  // One step of the twist: combines the upper bit of one word with the
  // lower bits of its successor and folds in the word further along.
  function automatic word_t mix_word(input word_t upper, input word_t lower,
                                     input word_t far_word);
    word_t y;
    word_t mag;
    y   = (upper & HIGH_BIT) | (lower & LOW_BITS);
    mag = y[0] ? TWIST_MATRIX : '0;
    return far_word ^ (y >> 1) ^ mag;
  endfunction

  // Output tempering of a table word.
  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

>>> hdl/mtrg_draw_if.sv
// ----------------------------------------------------------------------------
// Draw request channel
// Valid/ready channel carrying one request bit per transfer.
// ----------------------------------------------------------------------------
interface mtrg_draw_if;
  logic valid;
  logic ready;
  logic draw;

  modport source (output valid, output draw, input ready);
  modport sink   (input valid, input draw, output ready);
endinterface

>>> hdl/mtrg_word_if.sv
// ----------------------------------------------------------------------------
// Random word channel
// Valid/ready channel carrying one 32-bit random word per transfer.
// ----------------------------------------------------------------------------
interface mtrg_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

>>> hdl/mtrg_cell.sv
// ----------------------------------------------------------------------------
// State chain cell
// Holds one word of the generator state and takes its neighbour's word on
// every shift.
// ----------------------------------------------------------------------------
module mtrg_cell
  import mtrg_pkg::*;
(
  input  logic  clk,
  input  logic  shift_en,
  input  word_t d_in,
  output word_t q
);

  word_t value;

  // Take the neighbour's word when the chain moves on.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      value <= d_in;
    end
  end

  assign q = value;

endmodule

>>> hdl/mtrg_seeder.sv
// ----------------------------------------------------------------------------
// Table seeder
// Produces the initial table words from the seed, one word per cycle, by
// the multiplicative fill recurrence.
// ----------------------------------------------------------------------------
module mtrg_seeder
  import mtrg_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_we,
  input  word_t cfg_data,
  output fill_t fill
);

  logic   busy;
  word_t  word;
  count_t count;
  word_t  word_next;
  word_t  folded;

  // Next table word from the current one; index of the next word is count + 1.
  always_comb begin
    folded    = word ^ (word >> 30);
    word_next = word_t'(FILL_MULT * folded) + word_t'(count) + word_t'(1);
  end

  // Fill sequencing: a reset or a seed write restarts from the first word.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b1;
      count <= '0;
      word  <= SEED_DEFAULT;
    end else if (cfg_we) begin
      busy  <= 1'b1;
      count <= '0;
      word  <= cfg_data;
    end else if (busy) begin
      word  <= word_next;
      count <= count + count_t'(1);
      if (count == count_t'(STATE_WORDS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign fill.busy = busy;
  assign fill.word = word;

  // A seed write always starts a fresh fill from the first word.
  a_write_restarts: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (busy && count == '0))
    else $error("seed write did not restart the table fill");

  // The fill ends after the last table word has been produced.
  a_fill_ends: assert property (@(posedge clk) disable iff (rst)
    (busy && !cfg_we && count == count_t'(STATE_WORDS - 1)) |=> !busy)
    else $error("table fill overran the table length");

endmodule

>>> hdl/mtrg_out_reg.sv
// ----------------------------------------------------------------------------
// Output register
// Holds one tempered word until the receiver takes it, so a new word can be
// loaded in the same cycle as the held one leaves.
// ----------------------------------------------------------------------------
module mtrg_out_reg
  import mtrg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  word_t      data,
  output logic       free,
  mtrg_word_if.source word_out
);

  logic  valid;
  word_t held;

  // The register can take a word when empty or when the held word leaves.
  assign free = !valid || word_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (word_out.ready) begin
      valid <= 1'b0;
    end
  end

  // Word payload, tempered on the way in.
  always_ff @(posedge clk) begin
    if (load) begin
      held <= temper(data);
    end
  end

  assign word_out.valid       = valid;
  assign word_out.random_word = held;

endmodule

>>> hdl/mt19937_random_generator_core.sv
// ----------------------------------------------------------------------------
// MT19937 random generator core
// 32-bit Mersenne Twister with its state held in a shifting chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   draw_in  : request channel. Each transfer with draw set produces one
//              word; a transfer with draw clear is consumed and ignored.
//   word_out : result channel, one tempered 32-bit word per request, in
//              the standard MT19937 order.
//   cfg_we / cfg_data : seed register write. Writing it restarts the
//              sequence from the new seed.
//   A word appears on word_out in the cycle after its request transfer.
//   Throughput: one word per cycle while the receiver keeps up, since each
//   cycle the chain forms one twisted word from three fixed taps and shifts
//   by one cell. After reset, and after each seed write, the seeder fills
//   the chain one word per cycle through its single multiplier, and
//   draw_in.ready stays low for the whole fill. Reset seeds with 0x4141F00D.
//   When the receiver stalls, the finished word waits in the output
//   register; one further request is accepted only as that word leaves.
// ----------------------------------------------------------------------------
module mt19937_random_generator_core
  import mtrg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  mtrg_draw_if.sink   draw_in,
  mtrg_word_if.source word_out
);

  fill_t fill;
  word_t chain [STATE_WORDS];
  word_t insert_word;
  word_t twist_word;
  logic  shift_en;
  logic  out_free;
  logic  take_word;

  // Table fill from the seed.
  mtrg_seeder u_seeder (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .fill     (fill)
  );

  // Request handling: a word is produced for every accepted draw.
  assign draw_in.ready = !fill.busy && out_free;
  assign take_word     = draw_in.valid && draw_in.ready && draw_in.draw;

  // Next twisted word from the head of the chain and the far tap.
  assign twist_word  = mix_word(chain[0], chain[1], chain[SHIFT_OFFSET]);
  assign insert_word = fill.busy ? fill.word : twist_word;
  assign shift_en    = fill.busy || take_word;

  // The chain of state cells; new words enter at the tail.
  for (genvar i = 0; i < STATE_WORDS; i++) begin : g_chain
    if (i == STATE_WORDS - 1) begin : g_tail
      mtrg_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (insert_word),
        .q        (chain[i])
      );
    end else begin : g_body
      mtrg_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (chain[i+1]),
        .q        (chain[i])
      );
    end
  end

  // Tempering and output holding register.
  mtrg_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (take_word),
    .data     (twist_word),
    .free     (out_free),
    .word_out (word_out)
  );

  // Every word-producing request shows a word in the following cycle.
  a_word_follows: assert property (@(posedge clk) disable iff (rst)
    take_word |=> word_out.valid)
    else $error("requested word did not reach the output");

  // No request is taken while the table is being filled.
  a_no_draw_in_fill: assert property (@(posedge clk) disable iff (rst)
    fill.busy |-> !(draw_in.valid && draw_in.ready))
    else $error("request accepted during table fill");

  // The chain holds still when no word is produced and no fill runs.
  a_chain_holds: assert property (@(posedge clk) disable iff (rst)
    (!fill.busy && !take_word) |=> $stable(chain[0]))
    else $error("state chain moved without a request");

endmodule

>>> tb/mt19937_random_generator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MT19937 random generator core testbench
// Drives draw requests, mostly in bursts, against a receiver that mostly
// stalls at random. Every returned word is compared with a behavioural model
// of the 32-bit Mersenne Twister kept inside a small scoreboard. The run
// covers the reset seed, the all-zeros and all-ones seeds and a random seed,
// and crosses the table twist boundary.
// ----------------------------------------------------------------------------
module mt19937_random_generator_core_tb
  import mtrg_pkg::*;
();

  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned SETTLE_TICKS = 4;
  localparam int unsigned MAX_REPORTS  = 50;

  // Behavioural model of the generator together with the words still owed.
  class word_scoreboard;
    word_t       words [STATE_WORDS];
    int unsigned pos;
    word_t       pending [$];
    int unsigned errors;

    // Refill the table from a seed with the Knuth multiplier recurrence.
    function void reseed(word_t s);
      word_t p;
      words[0] = s;
      for (int unsigned i = 1; i < STATE_WORDS; i++) begin
        p        = words[i-1];
        words[i] = FILL_MULT * (p ^ (p >> 30)) + word_t'(i);
      end
      pos = STATE_WORDS;
    endfunction

    // Regenerate the whole table in place.
    function void twist_all();
      word_t joined;
      word_t mag;
      int unsigned nk;
      int unsigned fk;
      for (int unsigned k = 0; k < STATE_WORDS; k++) begin
        nk       = (k + 1) % STATE_WORDS;
        fk       = (k + SHIFT_OFFSET) % STATE_WORDS;
        joined   = {words[k][31], words[nk][30:0]};
        mag      = joined[0] ? TWIST_MATRIX : word_t'(0);
        words[k] = words[fk] ^ (joined >> 1) ^ mag;
      end
      pos = 0;
    endfunction

    // Next word of the sequence after output tempering.
    function word_t next_tempered_word();
      word_t t;
      if (pos >= STATE_WORDS) twist_all();
      t   = words[pos];
      pos = pos + 1;
      t   = t ^ (t >> 11);
      t   = t ^ ((t << 7) & TEMPER_B);
      t   = t ^ ((t << 15) & TEMPER_C);
      t   = t ^ (t >> 18);
      return t;
    endfunction

    // An accepted request with the draw bit clear leaves the model untouched.
    function void note_request(logic d);
      if (d) pending.push_back(next_tempered_word());
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(word_t got);
      word_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unrequested word %08h", got));
      end else begin
        want = pending.pop_front();
        if (got !== want)
          report_mismatch($sformatf("random_word %08h, predicted %08h", got, want));
      end
    endtask

    task check_leftovers();
      while (pending.size() != 0) begin
        report_mismatch($sformatf("word %08h never arrived", pending.pop_front()));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [31:0] cfg_data;

  mtrg_draw_if draw_if ();
  mtrg_word_if word_if ();

  word_scoreboard sb;

  // Receiver controls shared with the main sequence.
  logic rcv_stalls;
  logic hold_request;

  mt19937_random_generator_core u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .draw_in  (draw_if),
    .word_out (word_if)
  );

  // Clock with a 10 ns period.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog over the whole run.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // Receiver: a long hold-off on request, otherwise a repeating random
  // pattern of ready, or always ready.
  int unsigned hold_left     = 0;
  int unsigned stall_phase   = 0;
  logic [7:0]  ready_pattern = 8'hff;

  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      word_if.ready <= 1'b0;
      hold_left--;
    end else if (!rcv_stalls) begin
      word_if.ready <= 1'b1;
    end else begin
      if (stall_phase == 0)
        ready_pattern = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
      word_if.ready <= ready_pattern[stall_phase[2:0]];
      stall_phase = (stall_phase + 1) % 32;
    end
  end

  // Every word transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && word_if.valid && word_if.ready) sb.check_word(word_if.random_word);
  end

  // Offer one request and wait for its transfer.
  task send_one(input logic d);
    draw_if.valid <= 1'b1;
    draw_if.draw  <= d;
    @(posedge clk);
    while (!draw_if.ready) @(posedge clk);
    sb.note_request(d);
  endtask

  // Send a run of requests in bursts; zero_pct of them have the draw bit
  // clear. With bursty clear the requests go back to back.
  task send_items(input int unsigned count, input int unsigned zero_pct,
                  input logic bursty);
    int unsigned burst_left;
    int unsigned gap;
    logic d;
    burst_left = $urandom_range(1, 24);
    for (int unsigned n = 0; n < count; n++) begin
      d = ($urandom_range(0, 99) >= zero_pct);
      send_one(d);
      if (bursty) begin
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          if ($urandom_range(0, 39) == 0) begin
            // Pause until the block has returned everything owed.
            draw_if.valid <= 1'b0;
            @(posedge clk);
            while (sb.pending.size() != 0) @(posedge clk);
          end else if (gap != 0) begin
            draw_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end
    draw_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Seed write while the block is idle; the model refills at the same edge.
  task write_seed(input word_t s);
    cfg_we   <= 1'b1;
    cfg_data <= s;
    @(posedge clk);
    sb.reseed(s);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  // Main sequence.
  logic directed_draws [20] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
                                1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

  initial begin
    sb                = new();
    sb.errors         = 0;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_data          = '0;
    draw_if.valid     = 1'b0;
    draw_if.draw      = 1'b0;
    word_if.ready     = 1'b0;
    rcv_stalls        = 1'b0;
    hold_request      = 1'b0;
    sb.reseed(SEED_DEFAULT);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset seed: back-to-back directed requests, both draw values, the
    // first word-producing one forcing the initial twist.
    foreach (directed_draws[i]) send_one(directed_draws[i]);
    draw_if.valid <= 1'b0;
    @(posedge clk);

    // Long receiver hold-off while requests keep coming, so the input stalls.
    hold_request = 1'b1;
    send_items(20, 0, 1'b0);
    wait_drained();

    // Random bursts against a stalling receiver; runs past the next twist.
    rcv_stalls = 1'b1;
    send_items(630, 2, 1'b1);
    wait_drained();

    // Seed extremes and a random seed, each restarting the sequence.
    write_seed(32'h0000_0000);
    send_items(20, 10, 1'b1);
    wait_drained();
    write_seed(32'hffff_ffff);
    rcv_stalls = 1'b0;
    send_items(20, 10, 1'b0);
    wait_drained();
    rcv_stalls = 1'b1;
    write_seed(word_t'($urandom));
    send_items(20, 10, 1'b1);
    wait_drained();

    sb.check_leftovers();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
